>>> sv/mlp_relu_argmax_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MLP_RELU_ARGMAX_CLASSIFIER_DEFINES_SVH
`define MLP_RELU_ARGMAX_CLASSIFIER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/mra_pkg.sv
// Shared constants, types and the controller/datapath command struct.
// No dependencies.
package mra_pkg;
   localparam int Features  = 4;
   localparam int Hidden    = 32;
   localparam int Classes   = 3;
   localparam int WordBits  = 16;
   localparam int AccBits   = 40;
   localparam int B1Base    = Hidden * Features;
   localparam int W2Base    = B1Base + Hidden;
   localparam int B2Base    = W2Base + Classes * Hidden;
   localparam int ParamDepth = B2Base + Classes;
   localparam int AddrBits  = 9;
   localparam int HidBits   = $clog2(Hidden);
   localparam int FeatBits  = $clog2(Features);
   localparam int ClsBits   = 2;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // Datapath phase for each memory read issued by the controller.
   typedef enum logic [2:0] {
      PH_NONE, PH_B1, PH_W1, PH_B2, PH_W2
   } phase_type;

   typedef struct packed {
      logic                start;     // latch features, label and last flag
      logic                rd_en;     // read parameter at rd_addr
      logic [AddrBits-1:0] rd_addr;
      phase_type           phase;     // meaning of that read
      logic [FeatBits-1:0] feat;      // feature index for W1 reads
      logic [HidBits-1:0]  hid;       // hidden index for W1 end / W2 reads
      logic                hid_last;  // last W1 term of a hidden unit
      logic                cls_last;  // last W2 term of a class
      logic [ClsBits-1:0]  cls;
      logic                finish;    // all classes scored
   } dp_cmd_type;
endpackage

>>> sv/mra_ctrl.sv
// Sequencer for one classification: issues parameter reads in order.
// Depends on mra_pkg.
module mra_ctrl
   import mra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic       dp_done,
   output logic       busy,
   output dp_cmd_type cmd
);
   typedef enum logic [2:0] {S_IDLE, S_B1, S_W1, S_B2, S_W2, S_WAIT} state_type;

   state_type           state_ff, state_in;
   logic [HidBits-1:0]  hid_ff, hid_in;
   logic [FeatBits-1:0] feat_ff, feat_in;
   logic [ClsBits-1:0]  cls_ff, cls_in;

   // Next state and read commands.
   always_comb begin
      state_in = state_ff;
      hid_in   = hid_ff;
      feat_in  = feat_ff;
      cls_in   = cls_ff;
      cmd      = '0;
      cmd.hid  = hid_ff;
      cmd.feat = feat_ff;
      cmd.cls  = cls_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               cmd.start = 1'b1;
               hid_in    = '0;
               feat_in   = '0;
               cls_in    = '0;
               state_in  = S_B1;
            end
         end
         S_B1: begin
            cmd.rd_en   = 1'b1;
            cmd.phase   = PH_B1;
            cmd.rd_addr = AddrBits'(B1Base) + AddrBits'(hid_ff);
            state_in    = S_W1;
         end
         S_W1: begin
            cmd.rd_en    = 1'b1;
            cmd.phase    = PH_W1;
            cmd.rd_addr  = AddrBits'({hid_ff, feat_ff});
            cmd.hid_last = (feat_ff == FeatBits'(Features - 1));
            feat_in      = feat_ff + 1'b1;
            if (cmd.hid_last) begin
               feat_in = '0;
               hid_in  = hid_ff + 1'b1;
               state_in = (hid_ff == HidBits'(Hidden - 1)) ? S_B2 : S_B1;
            end
         end
         S_B2: begin
            cmd.rd_en   = 1'b1;
            cmd.phase   = PH_B2;
            cmd.rd_addr = AddrBits'(B2Base) + AddrBits'(cls_ff);
            hid_in      = '0;
            state_in    = S_W2;
         end
         S_W2: begin
            cmd.rd_en    = 1'b1;
            cmd.phase    = PH_W2;
            cmd.rd_addr  = AddrBits'(W2Base) + AddrBits'(cls_ff) * AddrBits'(Hidden)
                         + AddrBits'(hid_ff);
            cmd.cls_last = (hid_ff == HidBits'(Hidden - 1));
            hid_in       = hid_ff + 1'b1;
            if (cmd.cls_last) begin
               cls_in = cls_ff + 1'b1;
               if (cls_ff == ClsBits'(Classes - 1)) begin
                  cmd.finish = 1'b1;
                  state_in   = S_WAIT;
               end else begin
                  state_in = S_B2;
               end
            end
         end
         S_WAIT: begin
            if (dp_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hid_ff   <= '0;
         feat_ff  <= '0;
         cls_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hid_ff   <= hid_in;
         feat_ff  <= feat_in;
         cls_ff   <= cls_in;
      end
   end
endmodule

>>> sv/mra_datapath.sv
// Parameter memory, shared multiply-accumulate, hidden buffer, argmax and tally.
// Depends on mra_pkg and the assertion macro header.
`include "mlp_relu_argmax_classifier_defines.svh"
module mra_datapath
   import mra_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   input  logic                       wr_en,
   input  logic [AddrBits-1:0]        wr_addr,
   input  logic signed [WordBits-1:0] wr_data,
   input  logic signed [15:0]         feat_a,
   input  logic signed [15:0]         feat_b,
   input  logic signed [15:0]         feat_c,
   input  logic signed [15:0]         feat_d,
   input  logic [1:0]                 label,
   input  logic                       last,
   input  logic [4:0]                 shift,
   output logic                       done,
   output logic [1:0]                 res_class,
   output logic signed [31:0]         res_score,
   output logic                       res_match,
   output logic [15:0]                res_tally
);
   logic signed [WordBits-1:0] mem [ParamDepth];
   logic signed [WordBits-1:0] rd_data_ff;
   dp_cmd_type                 cmd_ff, cmd2_ff;
   logic signed [15:0]         x_ff [Features];
   logic [1:0]                 label_ff;
   logic                       last_ff;
   logic signed [31:0]         prod_ff, prod_in;
   logic signed [AccBits-1:0]  acc_ff, acc_in;
   logic [14:0]                hid_ff [Hidden];
   logic signed [31:0]         best_ff;
   logic [1:0]                 pred_ff;
   logic [15:0]                tally_ff;
   logic signed [WordBits-1:0] b_ff;
   logic                       done_ff;
   logic signed [AccBits-1:0]  fin_acc;
   logic signed [AccBits-1:0]  shifted;
   logic signed [31:0]         sat;
   logic                       take;
   logic [1:0]                 pred_n;
   logic signed [31:0]         best_n;
   logic                       match_n;

   // Parameter memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[cmd.rd_addr];
   end

   // Stage 2: multiply the read word by a feature or hidden value.
   always_comb begin
      prod_in = '0;
      if (cmd_ff.phase == PH_W1)
         prod_in = 32'(x_ff[cmd_ff.feat]) * 32'(rd_data_ff);
      else if (cmd_ff.phase == PH_W2)
         prod_in = $signed({17'd0, hid_ff[cmd_ff.hid]}) * 32'(rd_data_ff);
   end

   // Stage 3: accumulate, with biases loading the accumulator.
   always_comb begin
      if (cmd2_ff.phase == PH_B1 || cmd2_ff.phase == PH_B2)
         acc_in = AccBits'(b_ff);
      else if (cmd2_ff.phase == PH_W1 || cmd2_ff.phase == PH_W2)
         acc_in = acc_ff + AccBits'(prod_ff);
      else
         acc_in = acc_ff;
   end
   assign fin_acc = acc_in;
   assign shifted = fin_acc >>> shift;

   // Saturated class score and running argmax.
   always_comb begin
      if (fin_acc > 40'sd2147483647)       sat = 32'sh7FFFFFFF;
      else if (fin_acc < -40'sd2147483648) sat = 32'sh80000000;
      else                                 sat = fin_acc[31:0];
      take    = (cmd2_ff.cls == '0) || (sat > best_ff);
      pred_n  = take ? cmd2_ff.cls : pred_ff;
      best_n  = take ? sat : best_ff;
      match_n = (pred_n == label_ff);
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd;
      cmd2_ff <= cmd_ff;
      b_ff    <= rd_data_ff;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.start) begin
         x_ff[0]  <= feat_a;
         x_ff[1]  <= feat_b;
         x_ff[2]  <= feat_c;
         x_ff[3]  <= feat_d;
         label_ff <= label;
         last_ff  <= last;
      end
      // ReLU, shift and clip at the end of each hidden sum.
      if (cmd2_ff.phase == PH_W1 && cmd2_ff.hid_last) begin
         if (fin_acc <= 0)                 hid_ff[cmd2_ff.hid] <= '0;
         else if (shifted > 40'sd32767)    hid_ff[cmd2_ff.hid] <= 15'h7FFF;
         else                              hid_ff[cmd2_ff.hid] <= shifted[14:0];
      end
      if (cmd2_ff.phase == PH_W2 && cmd2_ff.cls_last) begin
         best_ff <= best_n;
         pred_ff <= pred_n;
      end
      if (cmd2_ff.finish) begin
         res_class <= pred_n;
         res_score <= best_n;
         res_match <= match_n;
         res_tally <= (match_n && tally_ff != 16'hFFFF) ? tally_ff + 1'b1 : tally_ff;
      end
   end

   // Batch tally and completion strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= cmd2_ff.finish;
         if (cmd2_ff.finish) begin
            if (last_ff)
               tally_ff <= '0;
            else if (match_n && tally_ff != 16'hFFFF)
               tally_ff <= tally_ff + 1'b1;
         end
      end
   end
   assign done = done_ff;

   `MRA_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `MRA_ASSERT_IMPL(a_match_ok, clock, reset, done_ff, res_match == (res_class == label_ff))
   `MRA_ASSERT_IMPL(a_class_range, clock, reset, done_ff, res_class != 2'd3)
endmodule

>>> sv/mlp_relu_argmax_classifier.sv
// Top level of the 4-32-3 perceptron classifier with output register.
// Depends on mra_pkg, mra_ctrl, mra_datapath and the assertion macro header.
// A load transaction writes one parameter word and returns nothing;
// another transaction may follow in the next cycle. A classify
// transaction makes 259 parameter reads through the single memory read
// port (32 x (1 bias + 4 weights) then 3 x (1 bias + 32 weights)); they
// pass through the read register and two pipeline stages, and the
// completion strobe then sets the result valid register. One sample is
// handled at a time, and the input stays stalled until the previous
// result has been taken, so no new sample enters before that.
`include "mlp_relu_argmax_classifier_defines.svh"
module mlp_relu_argmax_classifier
   import mra_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [8:0]         req_param_index,
   input  logic signed [15:0] req_param_value,
   input  logic signed [15:0] req_feature_a,
   input  logic signed [15:0] req_feature_b,
   input  logic signed [15:0] req_feature_c,
   input  logic signed [15:0] req_feature_d,
   input  logic [1:0]         req_expected_class,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_predicted_class,
   output logic signed [31:0] rsp_top_score,
   output logic               rsp_label_match,
   output logic [15:0]        rsp_correct_tally
);
   logic [4:0]         shift_ff;
   logic               rsp_valid_ff;
   logic               busy, done, accept, go, wr_en;
   dp_cmd_type         cmd;
   logic [1:0]         d_class;
   logic signed [31:0] d_score;
   logic               d_match;
   logic [15:0]        d_tally;

   // Stall while a sample runs or its result has not yet been taken.
   assign req_stall = busy || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign go        = accept && (req_op == OP_CLASSIFY);
   assign wr_en     = accept && (req_op == OP_LOAD)
                    && (req_param_index < AddrBits'(ParamDepth));

   mra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .dp_done(done), .busy(busy), .cmd(cmd)
   );

   mra_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .wr_en(wr_en), .wr_addr(req_param_index), .wr_data(req_param_value),
      .feat_a(req_feature_a), .feat_b(req_feature_b),
      .feat_c(req_feature_c), .feat_d(req_feature_d),
      .label(req_expected_class), .last(req_last_sample), .shift(shift_ff),
      .done(done), .res_class(d_class), .res_score(d_score),
      .res_match(d_match), .res_tally(d_tally)
   );

   // Configuration register and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 5'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) shift_ff <= csr_wr_data;
         if (done) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_class = d_class;
   assign rsp_top_score       = d_score;
   assign rsp_label_match     = d_match;
   assign rsp_correct_tally   = d_tally;

   `MRA_ASSERT_IMPL(a_no_overrun, clock, reset, done, !rsp_valid_ff)
   `MRA_ASSERT_NEXT(a_busy_after_go, clock, reset, go, busy)
   `MRA_ASSERT_IMPL(a_hold_result, clock, reset, rsp_valid_ff && rsp_stall, !done)
endmodule
